### hw/rtl/lsh_pkg.sv
`timescale 1ns / 1ps

package lsh_pkg;

    localparam int NUM_BUCKETS  = 25;
    localparam int COUNT_WIDTH  = 32;
    localparam int NUM_CHANNELS = 2;

    localparam int NUM_ENTRIES = NUM_BUCKETS * NUM_CHANNELS;
    localparam int ADDR_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    localparam int SAMPLE_W  = 16;
    localparam int WIDTH_W   = 8;
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]     RESET_BUCKET_WIDTH   = WIDTH_W'(20);
    localparam logic [SAMPLE_W-1:0]    RESET_SAMPLE_CEILING = SAMPLE_W'(10000);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX            = '1;
    localparam logic [BKT_W-1:0]       LAST_BUCKET          = BKT_W'(NUM_BUCKETS - 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_HIST  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_WIDTH   = 1'b0,
        CFG_SAMPLE_CEILING = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_RD,
        ST_WR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_WAIT
    } t_state;

    // one access to the bucket store per cycle: read or write at addr
    typedef struct packed {
        logic                   rd_en;
        logic                   wr_en;
        logic [ADDR_W-1:0]      addr;
        logic [COUNT_WIDTH-1:0] wr_data;
    } t_mem_cmd;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic ch,
                                                     input logic [BKT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = ch ? ADDR_W'(NUM_BUCKETS) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

### hw/rtl/lsh_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module lsh_div import lsh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_dividend,
    input  logic [WIDTH_W-1:0]  i_divisor,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [WIDTH_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [WIDTH_W-1:0]  r_div;

    logic [WIDTH_W:0]    w_trial;
    logic [WIDTH_W:0]    w_diff;
    logic                w_ge;
    logic [WIDTH_W-1:0]  n_rem;

    assign w_trial = {r_rem, r_quo[SAMPLE_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[WIDTH_W-1:0] : w_trial[WIDTH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SAMPLE_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hw/rtl/lsh_store.sv
`timescale 1ns / 1ps

// bucket counts for all channels; entries never written read as zero
module lsh_store import lsh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mem_cmd               i_cmd,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[i_cmd.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr];
            r_rd_vld  <= r_valid[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### hw/rtl/latency_stats_histogram.sv
`timescale 1ns / 1ps

// Latency statistics for two channels with a per-channel bucket histogram.
// One word is taken at a time; the block drops o_ready until the word is done.
// An add holds o_ready low through an update state, the steps of the shared
// serial divider that picks the bucket, a state to take the quotient, then a
// read and a write of the bucket store.
// A query gives one summary word on the cycle after accept. A histogram read
// first scans the channel's NUM_BUCKETS counts for the largest, then emits one
// word per bucket, each read, loaded and held through any output stall, since
// every count goes through the single store read port.
module latency_stats_histogram import lsh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_operation,
    input  logic                   i_channel,
    input  logic signed [15:0]     i_sample,

    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_is_histogram,
    output logic [15:0]            o_current_ms,
    output logic [15:0]            o_average_ms,
    output logic [15:0]            o_minimum_ms,
    output logic [15:0]            o_maximum_ms,
    output logic [5:0]             o_bucket_index,
    output logic [31:0]            o_bucket_count,
    output logic [31:0]            o_largest_count,
    output logic                   o_last
);

    t_state r_state;
    t_state n_state;

    logic [WIDTH_W-1:0]     r_bucket_width;
    logic [SAMPLE_W-1:0]    r_sample_ceiling;

    logic [SAMPLE_W-1:0]    r_cur [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]    r_avg [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]    r_min [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]    r_max [NUM_CHANNELS];

    t_op                    r_op;
    logic                   r_ch;
    logic [SAMPLE_W-1:0]    r_val;
    logic [BKT_W-1:0]       r_cnt;
    logic                   r_scan_pend;
    logic [COUNT_WIDTH-1:0] r_big;
    logic                   r_out_valid;

    logic                   r_is_hist;
    logic [SAMPLE_W-1:0]    r_cur_ms;
    logic [SAMPLE_W-1:0]    r_avg_ms;
    logic [SAMPLE_W-1:0]    r_min_ms;
    logic [SAMPLE_W-1:0]    r_max_ms;
    logic [5:0]             r_bkt_idx;
    logic [31:0]            r_bkt_cnt;
    logic [31:0]            r_big_cnt;
    logic                   r_last;

    logic                   w_ch_sel;
    logic signed [SAMPLE_W:0] w_x;
    logic [SAMPLE_W-1:0]    w_clamped;
    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SAMPLE_W-1:0]    w_quotient;
    logic [BKT_W-1:0]       w_bkt;
    logic [WIDTH_W-1:0]     w_divisor;
    logic [SAMPLE_W+2:0]    w_avg_sum;
    logic [COUNT_WIDTH-1:0] w_rd_data;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_ready;
    t_mem_cmd               c_mem;

    // input decode: channel 0 pings are one-way and get doubled
    assign w_ch_sel  = (NUM_CHANNELS == 1) ? 1'b0 : i_channel;
    assign w_x       = (w_ch_sel == 1'b0) ? {i_sample, 1'b0}
                                          : {i_sample[SAMPLE_W-1], i_sample};
    assign w_clamped = w_x[SAMPLE_W] ? '0 :
                       (w_x[SAMPLE_W-1:0] > r_sample_ceiling) ? r_sample_ceiling
                                                              : w_x[SAMPLE_W-1:0];

    assign w_in_acc  = i_valid && w_ready;
    assign w_out_acc = r_out_valid && i_ready;

    assign w_divisor = (r_bucket_width == '0) ? WIDTH_W'(1) : r_bucket_width;
    assign w_bkt     = (w_quotient >= SAMPLE_W'(NUM_BUCKETS)) ? LAST_BUCKET
                                                             : w_quotient[BKT_W-1:0];

    // 8*avg - avg + x, then drop three bits
    assign w_avg_sum = {r_avg[r_ch], 3'b000} - {3'b000, r_avg[r_ch]}
                     + {3'b000, r_val};
    assign w_inc     = (w_rd_data == COUNT_MAX) ? w_rd_data
                                                : w_rd_data + COUNT_WIDTH'(1);

    lsh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_val),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    lsh_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (c_mem),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (t_op'(i_operation))
                        OP_ADD:   n_state = ST_UPD;
                        OP_QUERY: n_state = ST_WAIT;
                        OP_HIST:  n_state = ST_SCAN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPD:       n_state = ST_DIV;
            ST_DIV:       if (w_div_done) n_state = ST_RD;
            ST_RD:        n_state = ST_WR;
            ST_WR:        n_state = ST_IDLE;
            ST_SCAN:      if (r_cnt == LAST_BUCKET) n_state = ST_SCAN_LAST;
            ST_SCAN_LAST: n_state = ST_EMIT_RD;
            ST_EMIT_RD:   n_state = ST_EMIT_LOAD;
            ST_EMIT_LOAD: n_state = ST_WAIT;
            ST_WAIT: begin
                if (w_out_acc) begin
                    if (r_op == OP_HIST && r_cnt != LAST_BUCKET) begin
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready       = 1'b0;
        w_div_start   = 1'b0;
        c_mem.rd_en   = 1'b0;
        c_mem.wr_en   = 1'b0;
        c_mem.addr    = entry_addr(r_ch, r_cnt);
        c_mem.wr_data = w_inc;
        case (r_state)
            ST_IDLE:    w_ready = 1'b1;
            ST_UPD:     w_div_start = 1'b1;
            ST_RD:      c_mem.rd_en = 1'b1;
            ST_WR:      c_mem.wr_en = 1'b1;
            ST_SCAN:    c_mem.rd_en = 1'b1;
            ST_EMIT_RD: c_mem.rd_en = 1'b1;
            default:    w_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_bucket_width   <= RESET_BUCKET_WIDTH;
            r_sample_ceiling <= RESET_SAMPLE_CEILING;
            r_op             <= OP_ADD;
            r_cnt            <= '0;
            r_scan_pend      <= 1'b0;
            r_out_valid      <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cur[c] <= '0;
                r_avg[c] <= '0;
                r_min[c] <= '1;
                r_max[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_scan_pend <= (r_state == ST_SCAN);

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BUCKET_WIDTH:   r_bucket_width   <= i_cfg_data[WIDTH_W-1:0];
                    CFG_SAMPLE_CEILING: r_sample_ceiling <= i_cfg_data[SAMPLE_W-1:0];
                    default:            r_bucket_width   <= r_bucket_width;
                endcase
            end

            if (w_in_acc) begin
                r_op  <= t_op'(i_operation);
                r_cnt <= '0;
                if (t_op'(i_operation) == OP_QUERY) begin
                    r_out_valid <= 1'b1;
                end
            end

            if (r_state == ST_UPD) begin
                r_cur[r_ch] <= r_val;
                r_avg[r_ch] <= w_avg_sum[SAMPLE_W+2:3];
                if (r_val < r_min[r_ch]) r_min[r_ch] <= r_val;
                if (r_val > r_max[r_ch]) r_max[r_ch] <= r_val;
            end

            if (r_state == ST_DIV && w_div_done) begin
                r_cnt <= w_bkt;
            end

            if (r_state == ST_SCAN) begin
                r_cnt <= (r_cnt == LAST_BUCKET) ? '0 : r_cnt + BKT_W'(1);
            end

            if (r_state == ST_EMIT_LOAD) begin
                r_out_valid <= 1'b1;
            end

            if (w_out_acc) begin
                r_out_valid <= 1'b0;
                if (r_op == OP_HIST && r_cnt != LAST_BUCKET) begin
                    r_cnt <= r_cnt + BKT_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch  <= w_ch_sel;
            r_val <= w_clamped;
            r_big <= '0;
            if (t_op'(i_operation) == OP_QUERY) begin
                r_is_hist <= 1'b0;
                r_cur_ms  <= r_cur[w_ch_sel];
                r_avg_ms  <= r_avg[w_ch_sel];
                r_min_ms  <= r_min[w_ch_sel];
                r_max_ms  <= r_max[w_ch_sel];
                r_bkt_idx <= '0;
                r_bkt_cnt <= '0;
                r_big_cnt <= '0;
                r_last    <= 1'b0;
            end
        end

        if (r_scan_pend && w_rd_data > r_big) begin
            r_big <= w_rd_data;
        end

        if (r_state == ST_EMIT_LOAD) begin
            r_is_hist <= 1'b1;
            r_cur_ms  <= '0;
            r_avg_ms  <= '0;
            r_min_ms  <= '0;
            r_max_ms  <= '0;
            r_bkt_idx <= 6'(r_cnt);
            r_bkt_cnt <= 32'(w_rd_data);
            r_big_cnt <= 32'(r_big);
            r_last    <= (r_cnt == LAST_BUCKET);
        end
    end

    assign o_ready         = w_ready;
    assign o_valid         = r_out_valid;
    assign o_is_histogram  = r_is_hist;
    assign o_current_ms    = r_cur_ms;
    assign o_average_ms    = r_avg_ms;
    assign o_minimum_ms    = r_min_ms;
    assign o_maximum_ms    = r_max_ms;
    assign o_bucket_index  = r_bkt_idx;
    assign o_bucket_count  = r_bkt_cnt;
    assign o_largest_count = r_big_cnt;
    assign o_last          = r_last;

    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("output word pending while taking input");

    a_last_is_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_is_histogram)
        else $error("last flag on a summary word");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_mem.wr_en |-> $past(c_mem.rd_en))
        else $error("bucket write without a preceding read");

endmodule
